@@ rtl/ede_pkg.sv @@
// ----------------------------------------------------------------------------
// ede_pkg
// Shared constants and types of the edit distance engine: string length
// limit, field widths, the token that moves along the cell chain and the
// control group that the front end broadcasts to every cell.
// ----------------------------------------------------------------------------
package ede_pkg;

  // longest string that the cell chain holds
  localparam int unsigned MaxLen = 64;
  // width of lengths, counters and row values (0..MaxLen)
  localparam int unsigned LenW   = $clog2(MaxLen + 1);
  localparam int unsigned SymW   = 8;
  localparam int unsigned DistW  = 7;

  // kind codes of an input beat
  localparam logic KindFirst  = 1'b0;
  localparam logic KindSecond = 1'b1;

  // one second-string character on its way along the chain
  typedef struct packed {
    logic            valid;
    logic            upd;   // character updates the row (not beyond the limit)
    logic            last;  // final character of the second string
    logic            fin;   // distance already frozen in left
    logic [SymW-1:0] sym;
    logic [LenW-1:0] left;  // new row value of the previous cell
    logic [LenW-1:0] diag;  // old row value of the previous cell
  } tok_t;

  // control broadcast from the front end to all cells
  typedef struct packed {
    logic            flush;    // drop tokens in flight, freeze rows
    logic            load;     // write a first-string character
    logic [LenW-1:0] load_pos; // cell number that takes it (1-based)
    logic [SymW-1:0] load_sym;
    logic [LenW-1:0] length;   // length of the first string
  } cell_ctl_t;

endpackage

@@ rtl/ede_in_if.sv @@
// ----------------------------------------------------------------------------
// ede_in_if
// Input channel of the edit distance engine: valid/ready with one
// character beat of either string.
// ----------------------------------------------------------------------------
interface ede_in_if;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [ede_pkg::SymW-1:0] symbol;
  logic                    last;

  modport source (output valid, kind, symbol, last, input ready);
  modport sink   (input valid, kind, symbol, last, output ready);
endinterface

@@ rtl/ede_out_if.sv @@
// ----------------------------------------------------------------------------
// ede_out_if
// Output channel of the edit distance engine: valid/ready with one
// distance beat per string pair.
// ----------------------------------------------------------------------------
interface ede_out_if;
  logic                     valid;
  logic                     ready;
  logic [ede_pkg::DistW-1:0] distance;
  logic                     overflow;

  modport source (output valid, distance, overflow, input ready);
  modport sink   (input valid, distance, overflow, output ready);
endinterface

@@ rtl/ede_cell.sv @@
// ----------------------------------------------------------------------------
// ede_cell
// One column of the distance row: holds a first-string character and its
// row entry, applies the edit recurrence to each passing token and hands
// the token on to the next cell through its token register.
// ----------------------------------------------------------------------------
module ede_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ede_pkg::cell_ctl_t       ctl_i,
  input  logic [ede_pkg::LenW-1:0] idx_i,
  input  ede_pkg::tok_t            tok_i,
  output ede_pkg::tok_t            tok_o
);
  import ede_pkg::*;

  logic [SymW-1:0] char_q;
  logic [LenW-1:0] row_q;
  tok_t            tok_q, tok_d;
  logic [LenW:0]   sub_cost, ins_cost, del_cost, best;
  logic            load_en, upd_en;

  // recurrence: min of substitute, insert, delete
  always_comb begin
    load_en  = ctl_i.load && (ctl_i.load_pos == idx_i);
    upd_en   = tok_i.valid && !ctl_i.flush && tok_i.upd && !tok_i.fin;
    sub_cost = {1'b0, tok_i.diag} + (LenW + 1)'(char_q != tok_i.sym);
    ins_cost = {1'b0, tok_i.left} + (LenW + 1)'(1);
    del_cost = {1'b0, row_q} + (LenW + 1)'(1);
    best     = (sub_cost < ins_cost) ? sub_cost : ins_cost;
    if (del_cost < best) begin
      best = del_cost;
    end
  end

  // outgoing token
  always_comb begin
    tok_d       = tok_i;
    tok_d.valid = tok_i.valid && !ctl_i.flush;
    if (!tok_i.fin) begin
      tok_d.diag = row_q;
      tok_d.left = tok_i.upd ? best[LenW-1:0] : row_q;
      tok_d.fin  = tok_i.last && (ctl_i.length == idx_i);
    end
  end

  // character and row entry; a load presets the entry to its column number
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      char_q <= ctl_i.load_sym;
      row_q  <= idx_i;
    end else if (upd_en) begin
      row_q  <= best[LenW-1:0];
    end
  end

  // token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ rtl/ede_ctrl.sv @@
// ----------------------------------------------------------------------------
// ede_ctrl
// Front end of the edit distance engine: pair bookkeeping, the first-string
// load broadcast, the row-zero boundary token, and the result stages that
// catch the frozen distance at the end of the chain.
// ----------------------------------------------------------------------------
module ede_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  ede_in_if.sink             in_i,
  ede_out_if.source          out_o,
  output ede_pkg::cell_ctl_t ctl_o,
  output ede_pkg::tok_t      tok_o,
  input  ede_pkg::tok_t      tok_i
);
  import ede_pkg::*;

  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             loading_q, loading_d;
  logic             draining_q, draining_d;
  logic             pend_q, pend_d;
  logic [LenW-1:0]  pdist_q, pdist_d;
  logic             ovalid_q, ovalid_d;
  logic [DistW-1:0] odist_q, odist_d;
  logic             oovf_q, oovf_d;
  tok_t             tok_q, tok_d;
  logic             acc, take_first, take_second, abandon, xfer;
  logic [LenW-1:0]  base_len;

  assign in_i.ready = !draining_q;

  always_comb begin
    acc         = in_i.valid && !draining_q;
    take_first  = acc && (in_i.kind == KindFirst);
    take_second = acc && (in_i.kind == KindSecond);
    abandon     = take_first && !loading_q;
    xfer        = pend_q && (!ovalid_q || out_o.ready);
    base_len    = abandon ? '0 : len_q;

    len_d      = len_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    loading_d  = loading_q;
    draining_d = draining_q;
    pend_d     = pend_q;
    pdist_d    = pdist_q;
    ovalid_d   = ovalid_q && !out_o.ready;
    odist_d    = odist_q;
    oovf_d     = oovf_q;

    ctl_o.flush    = abandon || xfer;
    ctl_o.load     = 1'b0;
    ctl_o.load_pos = base_len + LenW'(1);
    ctl_o.load_sym = in_i.symbol;
    ctl_o.length   = len_q;

    // boundary token carries row zero: old and new second-string count
    tok_d       = '0;
    tok_d.valid = take_second;
    tok_d.sym   = in_i.symbol;
    tok_d.last  = in_i.last;
    tok_d.diag  = cnt_q;
    tok_d.left  = cnt_q;
    tok_d.fin   = in_i.last && (len_q == '0);

    // first-string character: new pair if the previous first string had ended
    if (take_first) begin
      if (abandon) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end
      if (base_len < LenW'(MaxLen)) begin
        len_d      = base_len + LenW'(1);
        ctl_o.load = 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      loading_d = !in_i.last;
    end

    // second-string character enters the chain
    if (take_second) begin
      loading_d = 1'b0;
      if (cnt_q < LenW'(MaxLen)) begin
        cnt_d      = cnt_q + LenW'(1);
        tok_d.upd  = 1'b1;
        tok_d.left = cnt_q + LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (in_i.last) begin
        draining_d = 1'b1;
      end
    end

    // frozen distance leaves the chain
    if (tok_i.valid && tok_i.fin) begin
      pend_d  = 1'b1;
      pdist_d = tok_i.left;
    end

    // hand result to the output stage and start a new pair
    if (xfer) begin
      ovalid_d   = 1'b1;
      odist_d    = DistW'(pdist_q);
      oovf_d     = ovf_q;
      pend_d     = 1'b0;
      draining_d = 1'b0;
      len_d      = '0;
      cnt_d      = '0;
      ovf_d      = 1'b0;
      loading_d  = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      loading_q  <= 1'b1;
      draining_q <= 1'b0;
      pend_q     <= 1'b0;
      ovalid_q   <= 1'b0;
      tok_q      <= '0;
    end else begin
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      loading_q  <= loading_d;
      draining_q <= draining_d;
      pend_q     <= pend_d;
      ovalid_q   <= ovalid_d;
      tok_q      <= tok_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    pdist_q <= pdist_d;
    odist_q <= odist_d;
    oovf_q  <= oovf_d;
  end

  assign tok_o          = tok_q;
  assign out_o.valid    = ovalid_q;
  assign out_o.distance = odist_q;
  assign out_o.overflow = oovf_q;

endmodule

@@ rtl/edit_distance_engine_core.sv @@
// ----------------------------------------------------------------------------
// edit_distance_engine_core
// Levenshtein distance between two byte strings on a systolic cell chain.
//
// The in_i channel takes one character per beat: kind 0 for the first
// string, kind 1 for the second, last on the final character of each.
// First-string beats are taken one per cycle and preset one cell each.
// Second-string beats are also taken one per cycle; each enters the chain
// as a token and moves through the token register of each cell in turn,
// so the row wavefront is skewed across the cells. After the last
// second-string beat, ready stays low while that token runs the full
// chain and its distance passes the holding stage into the output
// register on out_o. Characters beyond MaxLen are dropped and set the
// overflow bit of the result. A first-string beat after the first string
// has ended abandons the pending pair and starts a new one.
// When out_o stalls, the finished distance waits in a holding stage and
// ready stays low until it moves into the output register; a new pair can
// then be loaded while the previous result still waits on out_o.
// Reset empties the chain and the output stage and expects a first string.
// ----------------------------------------------------------------------------
module edit_distance_engine_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ede_in_if.sink    in_i,
  ede_out_if.source out_o
);
  import ede_pkg::*;

  cell_ctl_t ctl;
  tok_t      chain_tok [MaxLen + 1];

  // front end and result stages
  ede_ctrl u_ede_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .ctl_o  (ctl),
    .tok_o  (chain_tok[0]),
    .tok_i  (chain_tok[MaxLen])
  );

  // chain of cells, cell j holds column j of the row
  for (genvar j = 1; j <= MaxLen; j++) begin : g_cell
    ede_cell u_ede_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .idx_i  (LenW'(j)),
      .tok_i  (chain_tok[j-1]),
      .tok_o  (chain_tok[j])
    );
  end

endmodule

@@ rtl/ede_checker.sv @@
// ----------------------------------------------------------------------------
// ede_checker
// Port-level checks of the edit distance engine, bound to the top level.
// ----------------------------------------------------------------------------
module ede_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_kind_i,
  input logic                      in_last_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [ede_pkg::DistW-1:0] out_distance_i
);
  import ede_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // end of second string closes the input until the result is out
  a_drain_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_kind_i == KindSecond) && in_last_i |=> !in_ready_i)
    else $error("input taken while distance in flight");

  // a new result appears only at the end of a drain
  a_out_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without a finished pair");

  // input reopens exactly when the result reaches the output stage
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> out_valid_i)
    else $error("input reopened without a result");

  // distance never exceeds the string limit
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (int'(out_distance_i) <= int'(MaxLen)))
    else $error("distance out of range");

endmodule

bind edit_distance_engine_core ede_checker u_ede_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_kind_i      (in_i.kind),
  .in_last_i      (in_i.last),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_distance_i (out_o.distance)
);
